FILE: hw/rtl/qctv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the quadrature counter / trigger / velocity block.
// No dependencies.
package qctv_pkg;

  localparam int TIME_W     = 64;
  localparam int POS_W      = 32;
  localparam int TRIG_W     = 16;
  localparam int PERIOD_W   = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = 51;
  localparam int CNT_W      = $clog2(PROD_W);
  localparam int MUL_W      = POS_W + PERIOD_W;

  localparam logic [PERIOD_W-1:0]   US_PER_S        = PERIOD_W'(1000000);
  localparam logic [TRIG_W-1:0]     TRIG_RESET      = TRIG_W'(100);
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET    = PERIOD_W'(10000);
  localparam logic [CFG_IDX_W-1:0]  REG_TRIG_INTERVAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  REG_VEL_PERIOD    = CFG_IDX_W'(1);
  localparam logic                  OP_EDGE  = 1'b0;
  localparam logic                  OP_INDEX = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } qctv_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic update_ref;
    logic mul;
    logic div_step;
    logic fin;
    logic emit;
  } qctv_cmd_t;

  typedef struct packed {
    logic is_index;
    logic upd_due;
    logic elapsed_nz;
    logic div_last;
    logic out_free;
  } qctv_status_t;

endpackage

FILE: hw/rtl/qctv_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for encoder event words and result words.
// Depends on qctv_pkg.
interface qctv_in_if;
  import qctv_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic              a_level;
  logic              b_level;
  logic [63:0]       time_us;

  modport source (output valid, operation, a_level, b_level, time_us, input ready);
  modport sink   (input valid, operation, a_level, b_level, time_us, output ready);
endinterface

interface qctv_out_if;
  import qctv_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  logic signed [POS_W-1:0] velocity;
  logic                    trigger_pulse;
  logic [POS_W-1:0]        trigger_total;
  logic                    index_seen;

  modport source (output valid, position, velocity, trigger_pulse, trigger_total, index_seen,
                  input ready);
  modport sink   (input valid, position, velocity, trigger_pulse, trigger_total, index_seen,
                  output ready);
endinterface

FILE: hw/rtl/quadrature_counter_trigger_velocity.sv
`timescale 1ns / 1ps
// Quadrature counter with camera trigger divider and velocity estimate: top level.
// Depends on qctv_pkg, qctv_if, qctv_ctrl, qctv_dp.
//
// events carries one word per encoder event: an A-channel edge (operation 0)
// or an index pulse (operation 1), with the A/B levels and a us timestamp.
// results returns exactly one word per event: position, velocity, trigger
// pulse, trigger count and the sticky index flag.
// Config: cfg_we/cfg_index/cfg_data write trigger_interval (0) or
// velocity_period_us (1); write only while idle.
// Sequence: an event that does not update velocity passes through the exec,
// check and emit states, and the block takes the next event only once its
// result is emitted. A velocity update runs a 51-step bit-serial divider (one
// quotient bit per cycle) between the check and emit states, and no new
// event is taken until that result is emitted too.
// The result sits in an output register; the next event is accepted while
// it waits. If the receiver stalls, the following result holds in the
// datapath until the register frees, and events stop being accepted.
// Reset (rst, synchronous) clears all counts and restores config defaults.
module quadrature_counter_trigger_velocity
  import qctv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  qctv_in_if.sink               events,
  qctv_out_if.source            results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  qctv_cmd_t    cmd;
  qctv_status_t st;
  logic [POS_W-1:0] pos_bits;
  logic [POS_W-1:0] vel_bits;

  qctv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (events.valid),
    .in_ready (events.ready),
    .st       (st),
    .cmd      (cmd)
  );

  qctv_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_operation      (events.operation),
    .in_a_level        (events.a_level),
    .in_b_level        (events.b_level),
    .in_time_us        (events.time_us),
    .out_valid         (results.valid),
    .out_ready         (results.ready),
    .out_position      (pos_bits),
    .out_velocity      (vel_bits),
    .out_trigger_pulse (results.trigger_pulse),
    .out_trigger_total (results.trigger_total),
    .out_index_seen    (results.index_seen)
  );

  assign results.position = $signed(pos_bits);
  assign results.velocity = $signed(vel_bits);

endmodule

FILE: hw/rtl/qctv_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences one event word through update, velocity divide and output.
// Depends on qctv_pkg.
module qctv_ctrl
  import qctv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  qctv_status_t st,
  output qctv_cmd_t    cmd
);

  qctv_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (!st.is_index && st.upd_due && st.elapsed_nz) state_next = ST_MUL;
        else state_next = ST_EMIT;
      end
      ST_MUL:   state_next = ST_DIV;
      ST_DIV:   if (st.div_last) state_next = ST_FIN;
      ST_FIN:   state_next = ST_EMIT;
      ST_EMIT:  if (st.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_EXEC:  cmd.exec = 1'b1;
      ST_CHECK: cmd.update_ref = !st.is_index && st.upd_due;
      ST_MUL:   cmd.mul = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_FIN:   cmd.fin = 1'b1;
      ST_EMIT:  cmd.emit = st.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

FILE: hw/rtl/qctv_dp.sv
`timescale 1ns / 1ps
// Datapath: position, trigger divider, config registers, serial velocity divider, output reg.
// Depends on qctv_pkg; driven by qctv_ctrl commands.
module qctv_dp
  import qctv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  qctv_cmd_t               cmd,
  output qctv_status_t            st,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_operation,
  input  logic                    in_a_level,
  input  logic                    in_b_level,
  input  logic [63:0]             in_time_us,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [POS_W-1:0]        out_position,
  output logic [POS_W-1:0]        out_velocity,
  output logic                    out_trigger_pulse,
  output logic [POS_W-1:0]        out_trigger_total,
  output logic                    out_index_seen
);

  logic [TRIG_W-1:0]   trig_interval;
  logic [PERIOD_W-1:0] vel_period;

  logic                op_q, a_q, b_q;
  logic [TIME_W-1:0]   time_q;

  logic [POS_W-1:0]    position_count;
  logic [TRIG_W-1:0]   trigger_phase;
  logic [POS_W-1:0]    trigger_counter;
  logic [TIME_W-1:0]   last_time;
  logic [POS_W-1:0]    last_pos;
  logic [POS_W-1:0]    velocity_value;
  logic                index_flag;
  logic                fired;

  logic [TIME_W-1:0]   elapsed;
  logic [POS_W-1:0]    mag;
  logic                neg;
  logic [PROD_W-1:0]   dvd;
  logic [TIME_W-1:0]   rem;
  logic [CNT_W-1:0]    cnt;

  logic [TRIG_W-1:0]   phase_next;
  logic [POS_W-1:0]    diff;
  logic [MUL_W-1:0]    prod_full;
  logic [TIME_W:0]     trial;
  logic [TIME_W:0]     trial_sub;
  logic                ge;
  logic                q_big;
  logic [POS_W-1:0]    vel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_interval <= TRIG_RESET;
      vel_period    <= PERIOD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_TRIG_INTERVAL) trig_interval <= cfg_data[TRIG_W-1:0];
      if (cfg_index == REG_VEL_PERIOD)    vel_period    <= cfg_data[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= in_operation;
      a_q    <= in_a_level;
      b_q    <= in_b_level;
      time_q <= in_time_us[TIME_W-1:0];
    end
  end

  assign phase_next = trigger_phase + TRIG_W'(1);
  assign diff       = position_count - last_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count  <= '0;
      trigger_phase   <= '0;
      trigger_counter <= '0;
      index_flag      <= 1'b0;
      fired           <= 1'b0;
    end else if (cmd.exec) begin
      if (op_q == OP_INDEX) begin
        index_flag <= 1'b1;
        fired      <= 1'b0;
      end else begin
        position_count <= (a_q == b_q) ? position_count + POS_W'(1)
                                       : position_count - POS_W'(1);
        if (phase_next >= trig_interval) begin
          trigger_phase   <= '0;
          trigger_counter <= trigger_counter + POS_W'(1);
          fired           <= 1'b1;
        end else begin
          trigger_phase <= phase_next;
          fired         <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) elapsed <= time_q - last_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
      last_pos  <= '0;
    end else if (cmd.update_ref) begin
      last_time <= time_q;
      last_pos  <= position_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update_ref) begin
      neg <= diff[POS_W-1];
      mag <= diff[POS_W-1] ? (~diff + POS_W'(1)) : diff;
    end
  end

  // restoring division, one quotient bit per cycle; quotient shifts into dvd
  assign prod_full = MUL_W'(mag) * MUL_W'(US_PER_S);
  assign trial     = {rem, dvd[PROD_W-1]};
  assign trial_sub = trial - {1'b0, elapsed};
  assign ge        = !trial_sub[TIME_W];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      dvd <= prod_full[PROD_W-1:0];
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[PROD_W-2:0], ge};
      rem <= ge ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign q_big = |dvd[PROD_W-1:POS_W-1];

  always_comb begin
    if (neg) vel_next = q_big ? {1'b1, {(POS_W-1){1'b0}}} : (~dvd[POS_W-1:0] + POS_W'(1));
    else     vel_next = q_big ? {1'b0, {(POS_W-1){1'b1}}} : dvd[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_value <= '0;
    end else if (cmd.fin) begin
      velocity_value <= vel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_position      <= position_count;
      out_velocity      <= velocity_value;
      out_trigger_pulse <= fired;
      out_trigger_total <= trigger_counter;
      out_index_seen    <= index_flag;
    end
  end

  assign st.is_index   = (op_q == OP_INDEX);
  assign st.upd_due    = elapsed >= TIME_W'(vel_period);
  assign st.elapsed_nz = |elapsed;
  assign st.div_last   = (cnt == CNT_W'(PROD_W - 1));
  assign st.out_free   = !out_valid || out_ready;

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result word loaded over an untaken word");

  a_fin_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> ($past(cmd.div_step) && $past(st.div_last)))
    else $error("velocity finished before the last divide step");

  a_vel_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.fin |=> $stable(velocity_value))
    else $error("velocity changed outside a divide finish");

endmodule
